[sv/cart_pendulum_euler_step_assert.svh]
// ----------------------------------------------------------------------------
// cart_pendulum_euler_step_assert
// Assertion macros shared by the cart-pendulum RTL.
// ----------------------------------------------------------------------------
`ifndef CART_PENDULUM_EULER_STEP_ASSERT_SVH
`define CART_PENDULUM_EULER_STEP_ASSERT_SVH

// same-cycle implication
`define CPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cpe_pkg.sv]
// ----------------------------------------------------------------------------
// cpe_pkg
// Types, register indexes, constants and the step program of the
// cart-pendulum plant emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

    localparam logic [2:0] CFG_BASE_MASS   = 3'd0;
    localparam logic [2:0] CFG_BOB_MASS    = 3'd1;
    localparam logic [2:0] CFG_ROD_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_FRICTION    = 3'd3;
    localparam logic [2:0] CFG_GRAVITY     = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd5;
    localparam logic [2:0] CFG_START_ANGLE = 3'd6;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] K_Q30  = 64'd652032874;

    localparam logic [5:0] ADV_START = 6'd0;
    localparam logic [5:0] RST_START = 6'd33;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_END
    } alu_op_t;

    typedef enum logic [4:0] {
        SL_ZERO, SL_MB, SL_MP, SL_LEN, SL_MU, SL_G, SL_DT, SL_F, SL_ST,
        SL_POS, SL_VEL, SL_ANG, SL_RATE, SL_AACC, SL_ACC, SL_S, SL_C,
        SL_NET, SL_MT, SL_MPL, SL_W2, SL_T1, SL_T2, SL_INNER, SL_NUM, SL_DEN
    } slot_t;

    typedef struct packed {
        alu_op_t op;
        slot_t   dst;
        slot_t   a;
        slot_t   b;
    } uop_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic clip;
    } alu_rsp_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048575;
            5'd11:   v = 32'd524287;
            5'd12:   v = 32'd262143;
            5'd13:   v = 32'd131071;
            5'd14:   v = 32'd65535;
            5'd15:   v = 32'd32767;
            5'd16:   v = 32'd16383;
            5'd17:   v = 32'd8191;
            5'd18:   v = 32'd4095;
            5'd19:   v = 32'd2047;
            5'd20:   v = 32'd1023;
            5'd21:   v = 32'd511;
            5'd22:   v = 32'd255;
            5'd23:   v = 32'd127;
            5'd24:   v = 32'd63;
            5'd25:   v = 32'd31;
            5'd26:   v = 32'd15;
            5'd27:   v = 32'd7;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic uop_t prog(input logic [5:0] pc);
        uop_t u;
        u = '{OP_END, SL_ZERO, SL_ZERO, SL_ZERO};
        case (pc)
            6'd0:  u = '{OP_MUL, SL_T1,    SL_MU,    SL_VEL};
            6'd1:  u = '{OP_SUB, SL_NET,   SL_F,     SL_T1};
            6'd2:  u = '{OP_ADD, SL_MT,    SL_MB,    SL_MP};
            6'd3:  u = '{OP_MUL, SL_MPL,   SL_MP,    SL_LEN};
            6'd4:  u = '{OP_MUL, SL_W2,    SL_RATE,  SL_RATE};
            6'd5:  u = '{OP_MUL, SL_T1,    SL_S,     SL_W2};
            6'd6:  u = '{OP_MUL, SL_T2,    SL_C,     SL_AACC};
            6'd7:  u = '{OP_SUB, SL_INNER, SL_T1,    SL_T2};
            6'd8:  u = '{OP_MUL, SL_T1,    SL_MPL,   SL_INNER};
            6'd9:  u = '{OP_ADD, SL_T1,    SL_NET,   SL_T1};
            6'd10: u = '{OP_DIV, SL_ACC,   SL_T1,    SL_MT};
            6'd11: u = '{OP_MUL, SL_T1,    SL_ACC,   SL_DT};
            6'd12: u = '{OP_ADD, SL_VEL,   SL_VEL,   SL_T1};
            6'd13: u = '{OP_MUL, SL_T1,    SL_VEL,   SL_DT};
            6'd14: u = '{OP_ADD, SL_POS,   SL_POS,   SL_T1};
            6'd15: u = '{OP_MUL, SL_T1,    SL_MT,    SL_G};
            6'd16: u = '{OP_MUL, SL_T1,    SL_T1,    SL_S};
            6'd17: u = '{OP_MUL, SL_T2,    SL_MPL,   SL_W2};
            6'd18: u = '{OP_MUL, SL_T2,    SL_T2,    SL_C};
            6'd19: u = '{OP_MUL, SL_T2,    SL_T2,    SL_S};
            6'd20: u = '{OP_SUB, SL_NUM,   SL_T1,    SL_T2};
            6'd21: u = '{OP_MUL, SL_T1,    SL_NET,   SL_C};
            6'd22: u = '{OP_SUB, SL_NUM,   SL_NUM,   SL_T1};
            6'd23: u = '{OP_MUL, SL_T1,    SL_C,     SL_C};
            6'd24: u = '{OP_MUL, SL_T1,    SL_MPL,   SL_T1};
            6'd25: u = '{OP_MUL, SL_T2,    SL_MT,    SL_LEN};
            6'd26: u = '{OP_SUB, SL_DEN,   SL_T2,    SL_T1};
            6'd27: u = '{OP_DIV, SL_AACC,  SL_NUM,   SL_DEN};
            6'd28: u = '{OP_MUL, SL_T1,    SL_AACC,  SL_DT};
            6'd29: u = '{OP_ADD, SL_RATE,  SL_RATE,  SL_T1};
            6'd30: u = '{OP_MUL, SL_T1,    SL_RATE,  SL_DT};
            6'd31: u = '{OP_ADD, SL_ANG,   SL_ANG,   SL_T1};
            6'd33: u = '{OP_ADD, SL_ANG,   SL_ST,    SL_ZERO};
            6'd34: u = '{OP_ADD, SL_POS,   SL_ZERO,  SL_ZERO};
            6'd35: u = '{OP_ADD, SL_VEL,   SL_ZERO,  SL_ZERO};
            6'd36: u = '{OP_ADD, SL_RATE,  SL_ZERO,  SL_ZERO};
            6'd37: u = '{OP_ADD, SL_AACC,  SL_ZERO,  SL_ZERO};
            6'd38: u = '{OP_ADD, SL_ACC,   SL_ZERO,  SL_ZERO};
            default: u = '{OP_END, SL_ZERO, SL_ZERO, SL_ZERO};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[sv/cpe_alu.sv]
// ----------------------------------------------------------------------------
// cpe_alu
// Shared saturating fixed-point unit: add, subtract, bit-serial multiply and
// restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_alu
    import cpe_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire alu_req_t     req,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output alu_rsp_t          rsp,
    output logic [W-1:0]      res
);

    localparam int QW = W + F;
    localparam int PW = (2 * W > QW) ? 2 * W : QW;
    localparam int CW = $clog2(QW + 1);
    localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] LIMP = PW'(MAXW);
    localparam logic [PW-1:0] LIMN = PW'(MINW);

    logic            busy_reg;
    logic            done_reg;
    logic            clip_reg;
    logic            neg_reg;
    alu_op_t         op_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   mc_reg;
    logic [QW-1:0]   ml_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    d_reg;
    logic [W-1:0]    res_reg;

    logic [W-1:0]    ma;
    logic [W-1:0]    mb;
    logic [W-1:0]    nb;
    logic            nb_clip;
    logic signed [W:0] sum;
    logic [W-1:0]    as_res;
    logic            as_clip;
    logic [W:0]      r2;
    logic            qbit;
    logic [PW-1:0]   mag;
    logic [W-1:0]    sat_res;
    logic            sat_clip;

    always_comb
    begin
        ma = a[W-1] ? W'(-a) : a;
        mb = b[W-1] ? W'(-b) : b;
        nb_clip = 1'b0;
        nb = b;
        if (req.op == OP_SUB)
        begin
            nb_clip = (b == MINW);
            nb = nb_clip ? MAXW : W'(-b);
        end
        sum = $signed({a[W-1], a}) + $signed({nb[W-1], nb});
        as_clip = nb_clip;
        as_res = sum[W-1:0];
        if (sum[W] != sum[W-1])
        begin
            as_clip = 1'b1;
            as_res = sum[W] ? MINW : MAXW;
        end
        r2 = {rem_reg, ml_reg[QW-1]};
        qbit = (r2 >= {1'b0, d_reg});
        mag = (op_reg == OP_MUL) ? (acc_reg >> F) : acc_reg;
        sat_clip = 1'b0;
        if (neg_reg)
        begin
            if (mag > LIMN)
            begin
                sat_clip = 1'b1;
                sat_res = MINW;
            end
            else
            begin
                sat_res = W'(-mag[W-1:0]);
            end
        end
        else
        begin
            if (mag > LIMP)
            begin
                sat_clip = 1'b1;
                sat_res = MAXW;
            end
            else
            begin
                sat_res = mag[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            clip_reg <= 1'b0;
            neg_reg  <= 1'b0;
            op_reg   <= OP_ADD;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            mc_reg   <= '0;
            ml_reg   <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg  <= req.op;
                neg_reg <= a[W-1] ^ b[W-1];
                case (req.op)
                    OP_ADD, OP_SUB:
                    begin
                        res_reg  <= as_res;
                        clip_reg <= as_clip;
                        done_reg <= 1'b1;
                    end
                    OP_MUL:
                    begin
                        acc_reg  <= '0;
                        mc_reg   <= PW'(ma);
                        ml_reg   <= QW'(mb);
                        cnt_reg  <= CW'(W);
                        busy_reg <= 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (mb == '0)
                        begin
                            res_reg  <= (a == '0) ? '0 : (a[W-1] ? MINW : MAXW);
                            clip_reg <= 1'b1;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg  <= '0;
                            ml_reg   <= {ma, {F{1'b0}}};
                            rem_reg  <= '0;
                            d_reg    <= mb;
                            cnt_reg  <= CW'(QW);
                            busy_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        res_reg  <= '0;
                        clip_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (op_reg == OP_MUL)
                    begin
                        if (ml_reg[0])
                        begin
                            acc_reg <= acc_reg + mc_reg;
                        end
                        mc_reg <= mc_reg << 1;
                        ml_reg <= ml_reg >> 1;
                    end
                    else
                    begin
                        rem_reg <= qbit ? W'(r2 - {1'b0, d_reg}) : r2[W-1:0];
                        acc_reg <= {acc_reg[PW-2:0], qbit};
                        ml_reg  <= ml_reg << 1;
                    end
                end
                else
                begin
                    res_reg  <= sat_res;
                    clip_reg <= sat_clip;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.clip = clip_reg;
    assign res      = res_reg;

endmodule

`default_nettype wire

[sv/cpe_cordic.sv]
// ----------------------------------------------------------------------------
// cpe_cordic
// Iterative sine and cosine: range reduction by shifted subtraction of two pi,
// quadrant fold, then one rotation-mode step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_cordic
    import cpe_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    parameter int N = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] angle,
    output logic              done,
    output logic [W-1:0]      sin_out,
    output logic [W-1:0]      cos_out
);

    localparam int RW = ((W > F + 4) ? W : F + 4) + 2;
    localparam int EW = RW + W;
    localparam int KW = $clog2(W);
    localparam int IW = $clog2(N);
    localparam logic [63:0] PI_F = PI_Q30 >> (30 - F);
    localparam logic signed [RW-1:0] PI_S   = RW'(PI_F);
    localparam logic signed [RW-1:0] TWO_S  = RW'(PI_F * 2);
    localparam logic signed [RW-1:0] HALF_S = RW'(PI_F >> 1);
    localparam logic signed [RW-1:0] K_S    = RW'(K_Q30 >> (30 - F));

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_RED  = 5'b00010,
        C_WRAP = 5'b00100,
        C_FOLD = 5'b01000,
        C_ROT  = 5'b10000
    } cor_state_t;

    cor_state_t          st_reg;
    logic                done_reg;
    logic [RW-1:0]       m_reg;
    logic                sgn_reg;
    logic [KW-1:0]       k_reg;
    logic signed [RW-1:0] r_reg;
    logic signed [RW-1:0] x_reg;
    logic signed [RW-1:0] y_reg;
    logic [IW-1:0]       i_reg;
    logic                flip_reg;

    logic [W-1:0]        amag;
    logic [EW-1:0]       sub_k;
    logic signed [RW-1:0] rs;
    logic signed [RW-1:0] rw;
    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] ys;
    logic signed [RW-1:0] t;

    always_comb
    begin
        amag  = angle[W-1] ? W'(-angle) : angle;
        sub_k = EW'(TWO_S) << k_reg;
        rs    = sgn_reg ? -$signed(m_reg) : $signed(m_reg);
        rw    = rs;
        if (rs > PI_S)
        begin
            rw = rs - TWO_S;
        end
        else if (rs < -PI_S)
        begin
            rw = rs + TWO_S;
        end
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        t  = $signed(RW'(atan_q30(5'(i_reg)) >> (30 - F)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
            m_reg    <= '0;
            sgn_reg  <= 1'b0;
            k_reg    <= '0;
            r_reg    <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            i_reg    <= '0;
            flip_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        m_reg   <= RW'(amag);
                        sgn_reg <= angle[W-1];
                        k_reg   <= KW'(W - 1);
                        st_reg  <= C_RED;
                    end
                end
                C_RED:
                begin
                    if (EW'(m_reg) >= sub_k)
                    begin
                        m_reg <= RW'(EW'(m_reg) - sub_k);
                    end
                    if (k_reg == '0)
                    begin
                        st_reg <= C_WRAP;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                C_WRAP:
                begin
                    r_reg  <= rw;
                    st_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    flip_reg <= 1'b0;
                    if (r_reg > HALF_S)
                    begin
                        r_reg    <= r_reg - PI_S;
                        flip_reg <= 1'b1;
                    end
                    else if (r_reg < -HALF_S)
                    begin
                        r_reg    <= r_reg + PI_S;
                        flip_reg <= 1'b1;
                    end
                    x_reg  <= K_S;
                    y_reg  <= '0;
                    i_reg  <= '0;
                    st_reg <= C_ROT;
                end
                C_ROT:
                begin
                    if (r_reg >= 0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        r_reg <= r_reg - t;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        r_reg <= r_reg + t;
                    end
                    if (i_reg == IW'(N - 1))
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= C_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign sin_out = flip_reg ? W'(-y_reg) : W'(y_reg);
    assign cos_out = flip_reg ? W'(-x_reg) : W'(x_reg);

endmodule

`default_nettype wire

[sv/cart_pendulum_euler_step.sv]
// ----------------------------------------------------------------------------
// cart_pendulum_euler_step
// Cart with inverted pendulum, one explicit Euler step per input transaction.
//
// Input stream: s_tdata carries the applied force, s_tuser the operation
// (0 advance one step, 1 restart from the start angle). Output stream: one
// transaction per input with the new state and the saturation flag.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while no step is in flight.
// An advance runs through the serial multiplier (19 products), the restoring
// divider (two quotients) and the CORDIC, which set how long it takes.
// Only one transaction is in flight; s_tready is high only when idle, and a
// finished result in the output register does not block the next input.
// If the receiver stalls, the block holds the next result until the output
// register frees. Reset clears the state to zero and the registers to their
// defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cart_pendulum_euler_step
    import cpe_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // applied_force
    input  wire logic [0:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cart_position, cart_velocity, cart_acceleration, pole_angle, pole_rate,
    // pole_angular_accel, elapsed_time, zero pad
    output logic [223:0]      m_tdata,
    output logic [0:0]        m_tuser,   // saturated
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

`include "cart_pendulum_euler_step_assert.svh"

    localparam int W  = WORD_BITS;
    localparam int CW = ((W > 33) ? W : 33) + 1;
    localparam logic signed [CW-1:0] MAXC = (CW'(1) << (W - 1)) - CW'(1);
    localparam logic signed [CW-1:0] MINC = -MAXC - CW'(1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_CRD   = 10'b0000000100,
        S_CGO   = 10'b0000001000,
        S_CWAIT = 10'b0000010000,
        S_CWR   = 10'b0000100000,
        S_RD    = 10'b0001000000,
        S_GO    = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    function automatic logic [W-1:0] clampv(input logic signed [32:0] v);
        logic signed [CW-1:0] e;
        e = CW'(v);
        if (e > MAXC)
        begin
            return MAXC[W-1:0];
        end
        if (e < MINC)
        begin
            return MINC[W-1:0];
        end
        return e[W-1:0];
    endfunction

    function automatic logic clipv(input logic signed [32:0] v);
        logic signed [CW-1:0] e;
        e = CW'(v);
        return (e > MAXC) || (e < MINC);
    endfunction

    function automatic logic [31:0] to32(input logic [W-1:0] v);
        logic signed [CW-1:0] e;
        e = CW'($signed(v));
        return e[31:0];
    endfunction

    state_t        state_reg;
    state_t        state_next;

    logic [30:0]   base_mass_reg;
    logic [30:0]   bob_mass_reg;
    logic [30:0]   rod_length_reg;
    logic [30:0]   friction_reg;
    logic [31:0]   gravity_reg;
    logic [16:0]   time_step_reg;
    logic [31:0]   start_angle_reg;

    logic          op_reg;
    logic [31:0]   force_reg;
    logic          flag_reg;
    logic [30:0]   time_reg;
    logic [2:0]    lc_reg;
    logic [5:0]    pc_reg;
    logic [W-1:0]  cos_hold_reg;

    logic [W-1:0]  mem [32];
    logic [31:0]   vld_reg;
    logic [W-1:0]  rda_reg;
    logic [W-1:0]  rdb_reg;

    logic [W-1:0]  pos_sh_reg;
    logic [W-1:0]  vel_sh_reg;
    logic [W-1:0]  acc_sh_reg;
    logic [W-1:0]  ang_sh_reg;
    logic [W-1:0]  rate_sh_reg;
    logic [W-1:0]  aacc_sh_reg;

    logic          m_tvalid_reg;
    logic [223:0]  m_tdata_reg;
    logic          m_tuser_reg;

    uop_t          uop;
    slot_t         ra;
    slot_t         rb;
    logic          wr_en;
    slot_t         wr_addr;
    logic [W-1:0]  wr_data;
    logic [W-1:0]  load_val;
    logic          accept;
    logic          out_load;
    logic          adv_clip;
    logic [31:0]   tsum;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;
    logic [W-1:0]  alu_res;
    logic          cor_start;
    logic          cor_done;
    logic [W-1:0]  cor_sin;
    logic [W-1:0]  cor_cos;

    assign uop      = prog(pc_reg);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign tsum     = {1'b0, time_reg} + {15'd0, time_step_reg};

    assign adv_clip = clipv({2'b00, base_mass_reg}) || clipv({2'b00, bob_mass_reg})
                   || clipv({2'b00, rod_length_reg}) || clipv({2'b00, friction_reg})
                   || clipv({gravity_reg[31], gravity_reg})
                   || clipv({16'd0, time_step_reg})
                   || clipv({s_tdata[31], s_tdata}) || tsum[31];

    always_comb
    begin
        case (lc_reg)
            3'd0:    load_val = clampv({2'b00, base_mass_reg});
            3'd1:    load_val = clampv({2'b00, bob_mass_reg});
            3'd2:    load_val = clampv({2'b00, rod_length_reg});
            3'd3:    load_val = clampv({2'b00, friction_reg});
            3'd4:    load_val = clampv({gravity_reg[31], gravity_reg});
            3'd5:    load_val = clampv({16'd0, time_step_reg});
            3'd6:    load_val = clampv({force_reg[31], force_reg});
            3'd7:    load_val = clampv({start_angle_reg[31], start_angle_reg});
            default: load_val = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ra          = uop.a;
        rb          = uop.b;
        wr_en       = 1'b0;
        wr_addr     = uop.dst;
        wr_data     = alu_res;
        alu_req     = '{1'b0, uop.op};
        cor_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_t'(5'(SL_MB) + 5'(lc_reg));
                wr_data = load_val;
                if (lc_reg == 3'd7)
                begin
                    state_next = op_reg ? S_RD : S_CRD;
                end
            end
            S_CRD:
            begin
                ra         = SL_ANG;
                state_next = S_CGO;
            end
            S_CGO:
            begin
                cor_start  = 1'b1;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (cor_done)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = SL_S;
                    wr_data    = cor_sin;
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = SL_C;
                wr_data    = cos_hold_reg;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = (uop.op == OP_END) ? S_DONE : S_GO;
            end
            S_GO:
            begin
                alu_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    wr_en      = 1'b1;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rda_reg <= vld_reg[ra] ? mem[ra] : '0;
        rdb_reg <= vld_reg[rb] ? mem[rb] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            base_mass_reg   <= 31'd65536;
            bob_mass_reg    <= 31'd65536;
            rod_length_reg  <= 31'd65536;
            friction_reg    <= 31'd0;
            gravity_reg     <= 32'd642908;
            time_step_reg   <= 17'd1092;
            start_angle_reg <= 32'd0;
            op_reg          <= 1'b0;
            force_reg       <= '0;
            flag_reg        <= 1'b0;
            time_reg        <= '0;
            lc_reg          <= '0;
            pc_reg          <= '0;
            cos_hold_reg    <= '0;
            vld_reg         <= '0;
            pos_sh_reg      <= '0;
            vel_sh_reg      <= '0;
            acc_sh_reg      <= '0;
            ang_sh_reg      <= '0;
            rate_sh_reg     <= '0;
            aacc_sh_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_MASS:   base_mass_reg   <= cfg_data[30:0];
                    CFG_BOB_MASS:    bob_mass_reg    <= cfg_data[30:0];
                    CFG_ROD_LENGTH:  rod_length_reg  <= cfg_data[30:0];
                    CFG_FRICTION:    friction_reg    <= cfg_data[30:0];
                    CFG_GRAVITY:     gravity_reg     <= cfg_data;
                    CFG_TIME_STEP:   time_step_reg   <= cfg_data[16:0];
                    CFG_START_ANGLE: start_angle_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept)
            begin
                op_reg    <= s_tuser[0];
                force_reg <= s_tdata;
                lc_reg    <= '0;
                if (s_tuser[0])
                begin
                    flag_reg <= clipv({start_angle_reg[31], start_angle_reg});
                    time_reg <= '0;
                end
                else
                begin
                    flag_reg <= adv_clip;
                    time_reg <= tsum[31] ? 31'h7FFFFFFF : tsum[30:0];
                end
            end

            if (state_reg == S_LOAD)
            begin
                lc_reg <= lc_reg + 1'b1;
                if (lc_reg == 3'd7)
                begin
                    pc_reg <= op_reg ? RST_START : ADV_START;
                end
            end

            if ((state_reg == S_CWAIT) && cor_done)
            begin
                cos_hold_reg <= cor_cos;
            end

            if ((state_reg == S_WAIT) && alu_rsp.done)
            begin
                pc_reg   <= pc_reg + 1'b1;
                flag_reg <= flag_reg | alu_rsp.clip;
            end

            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                case (wr_addr)
                    SL_POS:  pos_sh_reg  <= wr_data;
                    SL_VEL:  vel_sh_reg  <= wr_data;
                    SL_ACC:  acc_sh_reg  <= wr_data;
                    SL_ANG:  ang_sh_reg  <= wr_data;
                    SL_RATE: rate_sh_reg <= wr_data;
                    SL_AACC: aacc_sh_reg <= wr_data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {1'b0, time_reg, to32(aacc_sh_reg), to32(rate_sh_reg),
                                 to32(ang_sh_reg), to32(acc_sh_reg), to32(vel_sh_reg),
                                 to32(pos_sh_reg)};
                m_tuser_reg  <= flag_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    cpe_alu #(
        .W (W),
        .F (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rda_reg),
        .b     (rdb_reg),
        .rsp   (alu_rsp),
        .res   (alu_res)
    );

    cpe_cordic #(
        .W (W),
        .F (FRAC_BITS),
        .N (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (rda_reg),
        .done    (cor_done),
        .sin_out (cor_sin),
        .cos_out (cor_cos)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CPE_ASSERT_IMP(a_alu_free, alu_req.start, !alu_rsp.busy, "alu started while busy")
    `CPE_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "ready after accept")
    `CPE_ASSERT_IMP(a_wb_op, (state_reg == S_WAIT) && wr_en, uop.op != OP_END,
        "writeback from end op")
    `CPE_ASSERT_IMP(a_cordic_done, cor_done, state_reg == S_CWAIT, "stray cordic done")

endmodule

`default_nettype wire

[verif/tb_cart_pendulum_euler_step.sv]
// ----------------------------------------------------------------------------
// tb_cart_pendulum_euler_step
// Self-checking bench for the cart-pendulum Euler step block.
//
// A bit-accurate predictor of the plant (saturating Q16.16 arithmetic and a
// CORDIC sine/cosine) runs beside the block. Every accepted input transaction
// pushes the predicted state (all zero for typed rows) into a queue, and every
// output transaction is compared field by field against the head of that
// queue. A directed table comes first, then random steps under several
// register settings, with random stalls on both stream sides until item 280.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cart_pendulum_euler_step
    import cpe_pkg::*;
();

    localparam longint MAXW = 64'sd2147483647;
    localparam longint MINW = -64'sd2147483648;
    localparam logic OPER_ADVANCE = 1'b0;
    localparam logic OPER_RESTART = 1'b1;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [31:0] ang;
        logic [31:0] rate;
        logic [31:0] aacc;
        logic [30:0] tim;
        logic        sat;
    } plant_state_t;

    typedef struct {
        logic        op;
        logic [31:0] force_in;
        bit          typed;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    cart_pendulum_euler_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plant_state_t pending_states[$];
    int           fail_count = 0;
    int           idle_mode  = 0;
    int           item_count = 0;

    // predictor registers and state
    longint          p_mb, p_mp, p_len, p_mu, p_g, p_dt, p_st;
    longint          p_pos, p_vel, p_ang, p_rate, p_aacc;
    longint unsigned p_time;
    bit              clip;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("cart_pendulum_euler_step test failed");
        $finish;
    end

    function automatic longint clampw(longint a);
        if (a > MAXW)
        begin
            clip = 1'b1;
            return MAXW;
        end
        if (a < MINW)
        begin
            clip = 1'b1;
            return MINW;
        end
        return a;
    endfunction

    function automatic longint unsigned magn(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint from_mag(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim)
        begin
            clip = 1'b1;
            return neg ? MINW : MAXW;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return clampw(a + b);
    endfunction

    function automatic longint sat_neg(longint a);
        if (a == MINW)
        begin
            clip = 1'b1;
            return MAXW;
        end
        return -a;
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        return sat_add(a, sat_neg(b));
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return from_mag((a < 0) != (b < 0), (magn(a) * magn(b)) >> 16);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint unsigned d;
        d = magn(b);
        if (d == 0)
        begin
            clip = 1'b1;
            if (a == 0)
                return 0;
            return (a < 0) ? MINW : MAXW;
        end
        return from_mag((a < 0) != (b < 0), (magn(a) << 16) / d);
    endfunction

    function automatic void cordic_sincos(longint a, output longint sn, output longint cs);
        longint pi, two_pi, half, r, x, y, nx, t;
        bit     flip;
        pi     = longint'(PI_Q30 >> 14);
        two_pi = pi * 2;
        half   = pi >>> 1;
        r      = a % two_pi;
        flip   = 1'b0;
        if (r > pi)
            r -= two_pi;
        if (r < -pi)
            r += two_pi;
        if (r > half)
        begin
            r -= pi;
            flip = 1'b1;
        end
        else if (r < -half)
        begin
            r += pi;
            flip = 1'b1;
        end
        x = longint'(K_Q30 >> 14);
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            t = longint'(atan_q30(i[4:0])) >>> 14;
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r -= t;
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r += t;
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic plant_state_t euler_step_predict(logic op, logic [31:0] force_in);
        plant_state_t r;
        longint acc, s, c, net, mt, mpl, w2, inner, num, den;
        clip = 1'b0;
        acc  = 0;
        if (op == OPER_RESTART)
        begin
            p_ang  = p_st;
            p_pos  = 0;
            p_vel  = 0;
            p_rate = 0;
            p_aacc = 0;
            p_time = 0;
        end
        else
        begin
            cordic_sincos(p_ang, s, c);
            net    = sat_sub(longint'($signed(force_in)), fx_mul(p_mu, p_vel));
            mt     = sat_add(p_mb, p_mp);
            mpl    = fx_mul(p_mp, p_len);
            w2     = fx_mul(p_rate, p_rate);
            inner  = sat_sub(fx_mul(s, w2), fx_mul(c, p_aacc));
            acc    = fx_div(sat_add(net, fx_mul(mpl, inner)), mt);
            p_vel  = sat_add(p_vel, fx_mul(acc, p_dt));
            p_pos  = sat_add(p_pos, fx_mul(p_vel, p_dt));
            num    = sat_sub(fx_mul(fx_mul(mt, p_g), s),
                             fx_mul(fx_mul(fx_mul(mpl, w2), c), s));
            num    = sat_sub(num, fx_mul(net, c));
            den    = sat_sub(fx_mul(mt, p_len), fx_mul(mpl, fx_mul(c, c)));
            p_aacc = fx_div(num, den);
            p_rate = sat_add(p_rate, fx_mul(p_aacc, p_dt));
            p_ang  = sat_add(p_ang, fx_mul(p_rate, p_dt));
            p_time = p_time + longint'(p_dt);
            if (p_time > 64'h7FFFFFFF)
            begin
                p_time = 64'h7FFFFFFF;
                clip   = 1'b1;
            end
        end
        r.pos  = p_pos[31:0];
        r.vel  = p_vel[31:0];
        r.acc  = acc[31:0];
        r.ang  = p_ang[31:0];
        r.rate = p_rate[31:0];
        r.aacc = p_aacc[31:0];
        r.tim  = p_time[30:0];
        r.sat  = clip;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_BASE_MASS:   p_mb  = longint'(val[30:0]);
            CFG_BOB_MASS:    p_mp  = longint'(val[30:0]);
            CFG_ROD_LENGTH:  p_len = longint'(val[30:0]);
            CFG_FRICTION:    p_mu  = longint'(val[30:0]);
            CFG_GRAVITY:     p_g   = longint'($signed(val));
            CFG_TIME_STEP:   p_dt  = longint'(val[16:0]);
            CFG_START_ANGLE: p_st  = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [31:0] mb, logic [31:0] mp, logic [31:0] len,
                             logic [31:0] mu, logic [31:0] g, logic [31:0] dt,
                             logic [31:0] st);
        while (pending_states.size() != 0)
            @(negedge clk);
        write_reg(CFG_BASE_MASS, mb);
        write_reg(CFG_BOB_MASS, mp);
        write_reg(CFG_ROD_LENGTH, len);
        write_reg(CFG_FRICTION, mu);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_START_ANGLE, st);
    endtask

    // called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_step(logic op, logic [31:0] force_in, bit typed);
        plant_state_t exp_state;
        int           gap_pct;
        bit           done;
        gap_pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 86 : 0;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = force_in;
        s_tuser  = op;
        done     = 1'b0;
        while (!done)
        begin
            @(posedge clk);
            done = s_tready;
            @(negedge clk);
        end
        exp_state = euler_step_predict(op, force_in);
        if (typed)
        begin
            exp_state = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 1'b0};
        end
        pending_states.push_back(exp_state);
        item_count++;
        idle_mode = (item_count < 140) ? 0 : (item_count < 280) ? 1 : 2;
    endtask

    task automatic random_steps(int n);
        logic [31:0] f;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1))
                f = $urandom;
            else
                f = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
            send_step(($urandom_range(0, 19) == 0) ? OPER_RESTART : OPER_ADVANCE, f, 1'b0);
        end
    endtask

    always @(negedge clk)
    begin
        case (idle_mode)
            0:       m_tready <= ($urandom_range(0, 99) >= 86);
            1:       m_tready <= ($urandom_range(0, 99) >= 37);
            default: m_tready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        plant_state_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_states.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end
            else
            begin
                e = pending_states.pop_front();
                if (m_tdata[31:0] !== e.pos)
                begin
                    $error("cart_position exp %h got %h", e.pos, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== e.vel)
                begin
                    $error("cart_velocity exp %h got %h", e.vel, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== e.acc)
                begin
                    $error("cart_acceleration exp %h got %h", e.acc, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tdata[127:96] !== e.ang)
                begin
                    $error("pole_angle exp %h got %h", e.ang, m_tdata[127:96]);
                    fail_count++;
                end
                if (m_tdata[159:128] !== e.rate)
                begin
                    $error("pole_rate exp %h got %h", e.rate, m_tdata[159:128]);
                    fail_count++;
                end
                if (m_tdata[191:160] !== e.aacc)
                begin
                    $error("pole_angular_accel exp %h got %h", e.aacc, m_tdata[191:160]);
                    fail_count++;
                end
                if (m_tdata[222:192] !== e.tim)
                begin
                    $error("elapsed_time exp %h got %h", e.tim, m_tdata[222:192]);
                    fail_count++;
                end
                if (m_tuser[0] !== e.sat)
                begin
                    $error("saturated exp %b got %b", e.sat, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rows = '{
            '{OPER_RESTART, 32'h0000_0000, 1'b1},
            '{OPER_ADVANCE, 32'h0000_0000, 1'b0},
            '{OPER_ADVANCE, 32'h7FFF_FFFF, 1'b0},
            '{OPER_ADVANCE, 32'h8000_0000, 1'b0},
            '{OPER_ADVANCE, 32'h0000_0001, 1'b0},
            '{OPER_ADVANCE, 32'hFFFF_FFFF, 1'b0},
            '{OPER_RESTART, 32'hFFFF_FFFF, 1'b1},
            '{OPER_ADVANCE, 32'h0005_0000, 1'b0},
            '{OPER_ADVANCE, 32'h0005_0000, 1'b0},
            '{OPER_ADVANCE, 32'h0005_0000, 1'b0},
            '{OPER_ADVANCE, 32'hFFFB_0000, 1'b0},
            '{OPER_ADVANCE, 32'hFFFB_0000, 1'b0},
            '{OPER_ADVANCE, 32'hFFFB_0000, 1'b0},
            '{OPER_RESTART, 32'h1234_5678, 1'b1},
            '{OPER_ADVANCE, 32'h0000_0000, 1'b0},
            '{OPER_ADVANCE, 32'h0000_0000, 1'b0}
        };
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        p_mb = 65536; p_mp = 65536; p_len = 65536; p_mu = 0;
        p_g = 642908; p_dt = 1092; p_st = 0;
        p_pos = 0; p_vel = 0; p_ang = 0; p_rate = 0; p_aacc = 0; p_time = 0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_step(rows[i].op, rows[i].force_in, rows[i].typed);
        random_steps(60);
        s_tvalid = 1'b0;

        // heavy, long and fast: masses, length, friction and start angle at the top, gravity at the bottom
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'd65536, 32'h7FFF_FFFF);
        send_step(OPER_RESTART, 32'd0, 1'b0);
        random_steps(40);
        s_tvalid = 1'b0;

        // tiny masses and length drive the angular acceleration divisor to zero
        load_regs(32'd1, 32'd1, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
        send_step(OPER_RESTART, 32'd0, 1'b0);
        random_steps(40);
        s_tvalid = 1'b0;

        load_regs(32'd65536, 32'd16384, 32'd131072, 32'd6554, 32'd642908, 32'd1092,
                  32'd13107);
        send_step(OPER_RESTART, 32'd0, 1'b0);
        random_steps(100);
        s_tvalid = 1'b0;

        for (int k = 0; k < 4; k++)
        begin
            load_regs($urandom_range(1, 32'h0008_0000), $urandom_range(1, 32'h0008_0000),
                      $urandom_range(1, 32'h0008_0000), $urandom_range(0, 32'h0004_0000),
                      $urandom, $urandom_range(1, 65536), $urandom);
            send_step(OPER_RESTART, 32'd0, 1'b0);
            random_steps(35);
            s_tvalid = 1'b0;
        end

        while (pending_states.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        if (fail_count == 0)
            $display("cart_pendulum_euler_step test passed");
        else
            $display("cart_pendulum_euler_step test failed");
        $finish;
    end

endmodule
